@@ design/gtc_pkg.sv @@
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types and constants of the packed genotype range counter: item
// operation codes, register indexes, the configuration bundle and the packing
// of sixteen 2-bit genotypes in one word.
// ----------------------------------------------------------------------------
package gtc_pkg;

	// Item operation codes (carried in s_tuser)
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ACCUM = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register indexes (byte address 4*index)
	localparam logic [1:0] REG_LOWER  = 2'd0;
	localparam logic [1:0] REG_UPPER  = 2'd1;
	localparam logic [1:0] REG_FIELDS = 2'd2;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Word packing: field 0 of a word sits in bits 31:30
	localparam int PAIRS_PER_WORD = 16;
	localparam int PAIR_W         = 2;
	localparam int TOP_PAIR_SHIFT = 30;
	localparam int LANE_W         = 4;
	localparam int WIDX_W         = 8;
	localparam int FIELD_W        = 12;
	localparam int WORD_W         = 32;
	localparam int OUT_COUNT_W    = 16;

	// Reset values of the registers
	localparam logic [1:0]  LOWER_RST  = 2'd0;
	localparam logic [2:0]  UPPER_RST  = 3'd4;
	localparam logic [12:0] FIELDS_RST = 13'd4096;

	typedef struct packed {
		logic [1:0]  lower_bound;
		logic [2:0]  upper_bound;
		logic [12:0] field_count;
	} cfg_t;

endpackage

@@ design/gtc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gtc_cfg_regs
// APB register file: count bounds and number of fields in use.
// ----------------------------------------------------------------------------
module gtc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gtc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gtc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gtc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	output gtc_pkg::cfg_t                      cfg
);

	gtc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_ix;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign reg_ix = paddr[3:2];
	assign cfg    = cfg_q;

	// Write the addressed register at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_bound <= gtc_pkg::LOWER_RST;
			cfg_q.upper_bound <= gtc_pkg::UPPER_RST;
			cfg_q.field_count <= gtc_pkg::FIELDS_RST;
		end else if (wr_en) begin
			case (reg_ix)
				gtc_pkg::REG_LOWER:  cfg_q.lower_bound <= pwdata[1:0];
				gtc_pkg::REG_UPPER:  cfg_q.upper_bound <= pwdata[2:0];
				gtc_pkg::REG_FIELDS: cfg_q.field_count <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero elsewhere
	always_comb begin
		case (reg_ix)
			gtc_pkg::REG_LOWER:  prdata = {30'd0, cfg_q.lower_bound};
			gtc_pkg::REG_UPPER:  prdata = {29'd0, cfg_q.upper_bound};
			gtc_pkg::REG_FIELDS: prdata = {19'd0, cfg_q.field_count};
			default:             prdata = '0;
		endcase
	end

endmodule

@@ design/gtc_row_mem.sv @@
// ----------------------------------------------------------------------------
// gtc_row_mem
// Counter row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gtc_row_mem #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/gtc_row_update.sv @@
// ----------------------------------------------------------------------------
// gtc_row_update
// Applies one packed genotype word to a row of sixteen saturating counters.
// ----------------------------------------------------------------------------
module gtc_row_update #(
	parameter int MAX_FIELDS = 4096,
	parameter int COUNT_BITS = 16
) (
	input  gtc_pkg::cfg_t                                          cfg,
	input  logic [gtc_pkg::WIDX_W-1:0]                             word_index,
	input  logic [gtc_pkg::WORD_W-1:0]                             packed_genotypes,
	input  logic [gtc_pkg::PAIRS_PER_WORD-1:0][COUNT_BITS-1:0]     row_in,
	output logic [gtc_pkg::PAIRS_PER_WORD-1:0][COUNT_BITS-1:0]     row_out
);

	for (genvar j = 0; j < gtc_pkg::PAIRS_PER_WORD; j++) begin : g_lane
		logic [gtc_pkg::FIELD_W-1:0] field;
		logic [gtc_pkg::PAIR_W-1:0]  geno;
		logic                        in_use;
		logic                        in_range;

		assign field    = {word_index, gtc_pkg::LANE_W'(j)};
		assign geno     = packed_genotypes[gtc_pkg::TOP_PAIR_SHIFT - 2*j +: gtc_pkg::PAIR_W];
		assign in_use   = (13'(field) < cfg.field_count) && (32'(field) < 32'(MAX_FIELDS));
		assign in_range = (geno > cfg.lower_bound) && (3'(geno) < cfg.upper_bound);

		// Count the genotype, holding at the counter's maximum
		always_comb begin
			row_out[j] = row_in[j];
			if (in_use && in_range && (row_in[j] != '1)) begin
				row_out[j] = row_in[j] + COUNT_BITS'(1);
			end
		end
	end

endmodule

@@ design/packed_genotype_range_counter_core.sv @@
// ----------------------------------------------------------------------------
// packed_genotype_range_counter_core
// Per-field saturating counters of genotypes within a configured range,
// kept as rows of sixteen counters in a synchronous memory.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+----------------------------------
//   s       | in  | s_tvalid / s_tready   | tuser operation, tdata word/field
//   m       | out | m_tvalid / m_tready   | tdata count, read_field
//   apb     | in  | psel/penable/pready   | lower/upper bound, field count
//
// One item per cycle. An item reads its counter row in the cycle it is
// accepted and modifies and writes it back in the next; a write to the row
// the following item reads is forwarded. A clear drops the row valid flags,
// all held in flip-flops. Reset leaves every row invalid, so no clearing
// pass is needed. A read waiting for the output register to drain holds the
// input side; clear and accumulate never stall.
// ----------------------------------------------------------------------------
module packed_genotype_range_counter_core #(
	parameter int MAX_FIELDS = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [55:0]                    s_tdata,   // word_index[7:0], packed_genotypes[39:8],
	                                                  // field_index[51:40], zero[55:52]
	input  logic [1:0]                     s_tuser,   // operation[1:0]
	// Result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // count[15:0], read_field[27:16],
	                                                  // zero[31:28]
	// Configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gtc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gtc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gtc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int PAIRS     = gtc_pkg::PAIRS_PER_WORD;
	localparam int ALL_ROWS  = (MAX_FIELDS + PAIRS - 1) / PAIRS;
	// Word indexes reach 256 rows at most
	localparam int NROWS     = (ALL_ROWS < 256) ? ALL_ROWS : 256;
	localparam int ROW_W     = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int ROW_BITS  = PAIRS * COUNT_BITS;

	typedef logic [PAIRS-1:0][COUNT_BITS-1:0] row_t;

	gtc_pkg::cfg_t cfg;

	// Input unpacking
	logic [gtc_pkg::WIDX_W-1:0]  in_widx;
	logic [gtc_pkg::WORD_W-1:0]  in_word;
	logic [gtc_pkg::FIELD_W-1:0] in_fidx;
	logic [1:0]                  in_op;
	logic [gtc_pkg::WIDX_W-1:0]  in_row;
	logic                        in_acc;

	// Stage 1
	logic                        s1_vld_q;
	logic [1:0]                  op_s1;
	logic [gtc_pkg::WIDX_W-1:0]  row_s1;
	logic [gtc_pkg::WORD_W-1:0]  word_s1;
	logic [gtc_pkg::FIELD_W-1:0] fidx_s1;
	logic                        fwd_s1;
	logic                        s1_adv;
	logic                        row_hit;
	logic [ROW_W-1:0]            row_ix;
	row_t                        rd_data;
	row_t                        cur_row;
	row_t                        new_row;
	row_t                        wb_q;
	logic                        mem_we;
	logic [NROWS-1:0]            valid_q;

	// Result
	logic [COUNT_BITS-1:0]       lane_cnt;
	logic [31:0]                 cnt_wide;
	logic                        m_vld_q;
	logic [gtc_pkg::OUT_COUNT_W-1:0] m_count_q;
	logic [gtc_pkg::FIELD_W-1:0]     m_field_q;

	gtc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_widx = s_tdata[7:0];
	assign in_word = s_tdata[39:8];
	assign in_fidx = s_tdata[51:40];
	assign in_op   = s_tuser;
	assign in_row  = (in_op == gtc_pkg::OP_READ) ? in_fidx[11:4] : in_widx;
	assign in_acc  = s_tvalid & s_tready;

	// Advance stage 1 unless a read finds the output register full
	assign s1_adv   = s1_vld_q &
		!((op_s1 == gtc_pkg::OP_READ) && m_vld_q && !m_tready);
	assign s_tready = !s1_vld_q || s1_adv;

	gtc_row_mem #(
		.DEPTH  (NROWS),
		.WIDTH  (ROW_BITS),
		.ADDR_W (ROW_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (row_ix),
		.wdata (new_row),
		.re    (in_acc),
		.raddr (in_row[ROW_W-1:0]),
		.rdata (rd_data)
	);

	// Stage 1 item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_tready) begin
			s1_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= in_op;
			row_s1  <= in_row;
			word_s1 <= in_word;
			fidx_s1 <= in_fidx;
			// Forward when the row is written back at this very edge
			fwd_s1  <= mem_we && (row_s1 == in_row);
		end
	end

	// Row seen by stage 1: forwarded, stored or never written since clear
	assign row_hit = 32'(row_s1) < 32'(NROWS);
	assign row_ix  = row_s1[ROW_W-1:0];

	always_comb begin
		if (fwd_s1) begin
			cur_row = wb_q;
		end else if (row_hit && valid_q[row_ix]) begin
			cur_row = rd_data;
		end else begin
			cur_row = '0;
		end
	end

	gtc_row_update #(
		.MAX_FIELDS (MAX_FIELDS),
		.COUNT_BITS (COUNT_BITS)
	) u_upd (
		.cfg              (cfg),
		.word_index       (row_s1),
		.packed_genotypes (word_s1),
		.row_in           (cur_row),
		.row_out          (new_row)
	);

	assign mem_we = s1_adv && (op_s1 == gtc_pkg::OP_ACCUM) && row_hit;

	// Hold the last written row for forwarding
	always_ff @(posedge clk) begin
		if (mem_we) begin
			wb_q <= new_row;
		end
	end

	// Row valid flags: set on write back, drop all on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (s1_adv && (op_s1 == gtc_pkg::OP_CLEAR)) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[row_ix] <= 1'b1;
		end
	end

	// Read result: counters beyond the field range read as zero
	assign lane_cnt = cur_row[fidx_s1[3:0]];
	assign cnt_wide = (32'(fidx_s1) < 32'(MAX_FIELDS)) ? 32'(lane_cnt) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (s1_adv && (op_s1 == gtc_pkg::OP_READ)) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (op_s1 == gtc_pkg::OP_READ)) begin
			m_count_q <= cnt_wide[gtc_pkg::OUT_COUNT_W-1:0];
			m_field_q <= fidx_s1;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {4'd0, m_field_q, m_count_q};

	// Write back only comes from an accumulate in stage 1
	a_we_from_accum: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (s1_vld_q && (op_s1 == gtc_pkg::OP_ACCUM)))
		else $error("row write without accumulate item");

	// Input stalls only behind a read blocked by a full output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_vld_q && (op_s1 == gtc_pkg::OP_READ) && m_vld_q))
		else $error("input stalled without a blocked read");

	// A clear leaves no row valid
	a_clear_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (op_s1 == gtc_pkg::OP_CLEAR)) |=> (valid_q == '0))
		else $error("row still valid after clear");

endmodule
